### src/double_ended_queue_top_defines.svh
// Assertion macros for the deque ring buffer.
// Uses the enclosing module's clk and rst_n; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Invariant checked at every rising clock edge outside reset
`define DEQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define DEQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/deq_pkg.sv
// Shared constants for the deque ring buffer: field widths, request and
// status codes, default depth. No dependencies.
package deq_pkg;

  localparam int DEQ_DEPTH = 64;
  localparam int REQ_W     = 3;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_FWD   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_BWD   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

### src/double_ended_queue_top.sv
// Bounded double-ended queue of signed 32-bit values in a ring buffer.
// Depends on deq_pkg and double_ended_queue_top_defines.svh.
//
// Usage: one request per in_ transaction (push front/back, pop front/back,
// read forward/backward); results leave on the out_ channel, out_last marks
// the final result of a request. Both channels are valid/ready.
// Push and all error results appear on out_ in the cycle after the request
// is taken; a pop passes through the memory data register (one synchronous
// memory read) and then the output register. Reads stream one element per
// cycle and issue one memory read per cycle while out_ready is high.
// A push or error result can be produced every cycle while out_ready is
// high; after a pop, in_ready is held low until the popped value has left
// the memory data register. No request is taken while a read is streaming.
// Undefined request codes are taken and dropped.
// Reset clears the front index, count, and all valid flags; the element
// memory is not cleared, since only live entries are ever read.
// When out_ready is low the output register holds its result, the memory
// data register holds one more, and further reads and requests wait.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  out_item_value,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_last
);

  `include "double_ended_queue_top_defines.svh"

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic signed [VAL_W-1:0] mem [DEPTH];

  logic              state_r, state_nxt;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0]  rd_left_r, rd_left_nxt;
  logic              rd_fwd_r, rd_fwd_nxt;
  logic              rdata_vld_r, rdata_vld_nxt;
  logic signed [VAL_W-1:0] rdata_r;
  logic              rdata_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_val_r;
  logic [STAT_W-1:0] out_stat_r;
  logic              out_last_r;

  logic              in_fire, out_load, empty, full;
  logic [SUM_W-1:0]  tail_sum, back_sum;
  logic [IDX_W-1:0]  tail_pos, back_pos, front_prev, front_next, rd_step;
  logic              wr_en, rd_issue, rd_last;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic              direct_ld;
  logic signed [VAL_W-1:0] direct_val;
  logic [STAT_W-1:0] direct_st;

  assign in_ready = (state_r == S_IDLE) && !rdata_vld_r && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign out_load = rdata_vld_r && (!out_valid_r || out_ready);
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_FULL);

  // front + count lies below 2*DEPTH, so one conditional subtract wraps it
  assign tail_sum = SUM_W'(front_r) + SUM_W'(cnt_r);
  assign back_sum = tail_sum - SUM_W'(1);
  assign tail_pos = (tail_sum >= SUM_DEPTH) ? IDX_W'(tail_sum - SUM_DEPTH) : IDX_W'(tail_sum);
  assign back_pos = (back_sum >= SUM_DEPTH) ? IDX_W'(back_sum - SUM_DEPTH) : IDX_W'(back_sum);
  assign front_prev = (front_r == '0) ? IDX_LAST : front_r - IDX_W'(1);
  assign front_next = (front_r == IDX_LAST) ? '0 : front_r + IDX_W'(1);
  assign rd_step = rd_fwd_r ? ((rd_pos_r == IDX_LAST) ? '0 : rd_pos_r + IDX_W'(1))
                            : ((rd_pos_r == '0) ? IDX_LAST : rd_pos_r - IDX_W'(1));

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    cnt_nxt     = cnt_r;
    rd_pos_nxt  = rd_pos_r;
    rd_left_nxt = rd_left_r;
    rd_fwd_nxt  = rd_fwd_r;
    wr_en       = 1'b0;
    wr_addr     = tail_pos;
    rd_issue    = 1'b0;
    rd_addr     = rd_pos_r;
    rd_last     = 1'b1;
    direct_ld   = 1'b0;
    direct_val  = '0;
    direct_st   = STAT_OK;
    if (in_fire) begin
      unique case (in_req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          direct_ld = 1'b1;
          if (full) begin
            direct_st = STAT_FULL;
          end else begin
            wr_en      = 1'b1;
            direct_val = in_value;
            cnt_nxt    = cnt_r + CNT_W'(1);
            if (in_req_type == REQ_PUSH_FRONT) begin
              wr_addr   = front_prev;
              front_nxt = front_prev;
            end
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (empty) begin
            direct_ld = 1'b1;
            direct_st = STAT_EMPTY;
          end else begin
            rd_issue = 1'b1;
            cnt_nxt  = cnt_r - CNT_W'(1);
            if (in_req_type == REQ_POP_FRONT) begin
              rd_addr   = front_r;
              front_nxt = front_next;
            end else begin
              rd_addr = back_pos;
            end
          end
        end
        REQ_READ_FWD, REQ_READ_BWD: begin
          if (empty) begin
            direct_ld = 1'b1;
            direct_st = STAT_EMPTY;
          end else begin
            state_nxt   = S_READ;
            rd_fwd_nxt  = (in_req_type == REQ_READ_FWD);
            rd_pos_nxt  = (in_req_type == REQ_READ_FWD) ? front_r : back_pos;
            rd_left_nxt = cnt_r;
          end
        end
        default: ;
      endcase
    end else if ((state_r == S_READ) && (!rdata_vld_r || out_load)) begin
      // stream: next read only when the data register is free next cycle
      rd_issue    = 1'b1;
      rd_last     = (rd_left_r == CNT_W'(1));
      rd_left_nxt = rd_left_r - CNT_W'(1);
      rd_pos_nxt  = rd_step;
      if (rd_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_comb begin
    if (rd_issue) begin
      rdata_vld_nxt = 1'b1;
    end else if (out_load) begin
      rdata_vld_nxt = 1'b0;
    end else begin
      rdata_vld_nxt = rdata_vld_r;
    end
    if (direct_ld || out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // element memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    if (rd_issue) begin
      rdata_r      <= mem[rd_addr];
      rdata_last_r <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (direct_ld) begin
      out_val_r  <= direct_val;
      out_stat_r <= direct_st;
      out_last_r <= 1'b1;
    end else if (out_load) begin
      out_val_r  <= rdata_r;
      out_stat_r <= STAT_OK;
      out_last_r <= rdata_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      cnt_r       <= '0;
      rd_pos_r    <= '0;
      rd_left_r   <= '0;
      rd_fwd_r    <= 1'b0;
      rdata_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      cnt_r       <= cnt_nxt;
      rd_pos_r    <= rd_pos_nxt;
      rd_left_r   <= rd_left_nxt;
      rd_fwd_r    <= rd_fwd_nxt;
      rdata_vld_r <= rdata_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_item_value = out_val_r;
  assign out_status     = out_stat_r;
  assign out_last       = out_last_r;

  `DEQ_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_FULL, "element count exceeds depth")
  `DEQ_ASSERT_IMP(a_read_left, state_r == S_READ, rd_left_r != '0, "read with nothing left")
  `DEQ_ASSERT_NEXT(a_rd_data, rd_issue, rdata_vld_r, "memory read data lost")
  `DEQ_ASSERT_IMP(a_no_overrun, rdata_vld_r && !out_load, !rd_issue, "read data overwritten")

endmodule

### tb/double_ended_queue_top_test.sv
// Self-checking testbench for double_ended_queue_top: random and directed deque
// requests, predicted results compared transaction by transaction.
// Depends on deq_pkg and the double_ended_queue_top RTL.
`timescale 1ns / 1ps

module double_ended_queue_top_test;
  import deq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;
  localparam int ITEM_TARGET = 350;

  typedef struct {
    logic [REQ_W-1:0]        req;
    logic signed [VAL_W-1:0] value;
    int                      idle_pct;
    int                      stall_pct;
    bit                      drain_first;
  } deque_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
    logic                    last;
  } deque_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [REQ_W-1:0]        in_req_type;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_item_value;
  logic [STAT_W-1:0]       out_status;
  logic                    out_last;

  deque_req_t    request_queue[$];
  deque_result_t deque_outputs_due[$];
  deque_req_t    next_req;
  deque_result_t got_result;
  deque_result_t want_result;

  // predictor's copy of the ring
  logic signed [VAL_W-1:0] ring_mem [DEQ_DEPTH];
  int                      ring_front;
  int                      ring_count;

  int mismatch_count;
  int stall_pct;
  bit in_taken;

  double_ended_queue_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item_value (out_item_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic push_result(logic signed [VAL_W-1:0] value, logic [STAT_W-1:0] status,
                             logic last);
    deque_result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    deque_outputs_due.push_back(r);
  endtask

  task automatic apply_deque_request(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] val);
    int pos;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (ring_count >= DEQ_DEPTH) begin
          push_result('0, STAT_FULL, 1'b1);
        end else begin
          if (req == REQ_PUSH_FRONT) begin
            ring_front = (ring_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
            pos = ring_front;
          end else begin
            pos = (ring_front + ring_count) % DEQ_DEPTH;
          end
          ring_mem[pos] = val;
          ring_count++;
          push_result(val, STAT_OK, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (ring_count == 0) begin
          push_result('0, STAT_EMPTY, 1'b1);
        end else begin
          if (req == REQ_POP_FRONT) begin
            pos = ring_front;
            ring_front = (ring_front + 1) % DEQ_DEPTH;
          end else begin
            pos = (ring_front + ring_count - 1) % DEQ_DEPTH;
          end
          ring_count--;
          push_result(ring_mem[pos], STAT_OK, 1'b1);
        end
      end
      REQ_READ_FWD, REQ_READ_BWD: begin
        if (ring_count == 0) begin
          push_result('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            pos = (req == REQ_READ_FWD) ? (ring_front + i) % DEQ_DEPTH
                                        : (ring_front + ring_count - 1 - i) % DEQ_DEPTH;
            push_result(ring_mem[pos], STAT_OK, (i + 1 == ring_count));
          end
        end
      end
      default: ; // undefined codes are dropped
    endcase
  endtask

  // idling and stalling phase follows position in the stimulus
  task automatic add_request(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] value);
    deque_req_t r;
    int idx;
    idx = request_queue.size();
    r.req   = req;
    r.value = value;
    if (idx < 90) begin
      r.idle_pct = 0;  r.stall_pct = 0;
    end else if (idx < 180) begin
      r.idle_pct = 46; r.stall_pct = 0;
    end else if (idx < 270) begin
      r.idle_pct = 0;  r.stall_pct = 46;
    end else begin
      r.idle_pct = 37; r.stall_pct = 37;
    end
    r.drain_first = (idx == 90 || idx == 180 || idx == 270 || $urandom_range(39) == 0);
    request_queue.push_back(r);
  endtask

  function automatic logic [REQ_W-1:0] pick_request(int mode);
    int push_lim, pop_lim, read_lim, r;
    case (mode)
      0:       begin push_lim = 60; pop_lim = 80; read_lim = 95; end
      1:       begin push_lim = 25; pop_lim = 80; read_lim = 95; end
      default: begin push_lim = 40; pop_lim = 80; read_lim = 97; end
    endcase
    r = $urandom_range(99);
    if (r < push_lim) return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    if (r < pop_lim)  return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    if (r < read_lim) return $urandom_range(1) ? REQ_READ_BWD : REQ_READ_FWD;
    return $urandom_range(1) ? REQ_UNDEF_HI : REQ_UNDEF_LO;
  endfunction

  // driver and receiver: everything changes on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (request_queue.size() != 0 &&
            (!request_queue[0].drain_first || deque_outputs_due.size() == 0) &&
            $urandom_range(99) >= request_queue[0].idle_pct) begin
          next_req    = request_queue.pop_front();
          stall_pct   = next_req.stall_pct;
          in_valid    <= 1'b1;
          in_req_type <= next_req.req;
          in_value    <= next_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) apply_deque_request(in_req_type, in_value);
      if (out_valid && out_ready) begin
        got_result.value  = out_item_value;
        got_result.status = out_status;
        got_result.last   = out_last;
        if (deque_outputs_due.size() == 0) begin
          report_mismatch($sformatf("result with none due: value %0d status %0d last %0d",
                                    got_result.value, got_result.status, got_result.last));
        end else begin
          want_result = deque_outputs_due.pop_front();
          if (got_result.value !== want_result.value)
            report_mismatch($sformatf("item_value got %0d want %0d",
                                      got_result.value, want_result.value));
          if (got_result.status !== want_result.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      got_result.status, want_result.status));
          if (got_result.last !== want_result.last)
            report_mismatch($sformatf("last got %0d want %0d",
                                      got_result.last, want_result.last));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int  mode;
    int  seg_len;
    bit  filled;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_PUSH_FRONT;
    in_value       = '0;
    out_ready      = 1'b0;
    stall_pct      = 0;
    mismatch_count = 0;
    ring_front     = 0;
    ring_count     = 0;
    filled         = 1'b0;

    // directed: empty-store errors, dropped codes, value extremes, every operation
    add_request(REQ_READ_FWD, 32'sd5);
    add_request(REQ_READ_BWD, -32'sd5);
    add_request(REQ_POP_FRONT, 32'sd1);
    add_request(REQ_POP_BACK, -32'sd1);
    add_request(REQ_UNDEF_LO, 32'sd77);
    add_request(REQ_UNDEF_HI, -32'sd77);
    add_request(REQ_PUSH_FRONT, 32'sh7fff_ffff);
    add_request(REQ_PUSH_BACK, 32'sh8000_0000);
    add_request(REQ_PUSH_FRONT, -32'sd1);
    add_request(REQ_PUSH_BACK, 32'sd0);
    add_request(REQ_PUSH_BACK, 32'sd1);
    add_request(REQ_READ_FWD, 32'sd0);
    add_request(REQ_READ_BWD, 32'sd0);
    add_request(REQ_POP_BACK, 32'sd0);
    add_request(REQ_POP_FRONT, 32'sd0);
    add_request(REQ_UNDEF_LO, 32'sd0);
    add_request(REQ_READ_FWD, 32'sd0);
    add_request(REQ_POP_FRONT, 32'sd0);
    add_request(REQ_POP_BACK, 32'sd0);
    add_request(REQ_POP_BACK, 32'sd0);
    add_request(REQ_PUSH_BACK, $urandom);
    add_request(REQ_READ_BWD, 32'sd0);
    add_request(REQ_POP_FRONT, 32'sd0);

    while (request_queue.size() < ITEM_TARGET) begin
      if (!filled && request_queue.size() > 150) begin
        // run the store up to full and past it, read it whole, then empty it
        for (int i = 0; i < DEQ_DEPTH + 4; i++)
          add_request($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom);
        add_request(REQ_READ_FWD, $urandom);
        add_request(REQ_READ_BWD, $urandom);
        for (int i = 0; i < DEQ_DEPTH + 3; i++)
          add_request($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT, $urandom);
        filled = 1'b1;
      end else begin
        mode    = $urandom_range(2);
        seg_len = $urandom_range(8, 40);
        for (int i = 0; i < seg_len; i++) add_request(pick_request(mode), $urandom);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // sampled clear of the falling edge so the driver's update has landed
    do begin
      @(negedge clk);
      #1;
    end while (request_queue.size() != 0 || in_valid || deque_outputs_due.size() != 0);
    stall_pct = 0;
    repeat (20) @(negedge clk);

    if (mismatch_count == 0 && deque_outputs_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
